/* design/ddcb_pkg.sv */
// Shared types, constants and helper functions for the DMA descriptor chain builder.
// Used by the front end, the request queue, the back end and the top level.
// No dependencies.
package ddcb_pkg;

    // Default values for the top-level parameters.
    localparam int DEF_PAGE_BYTES            = 4096;
    localparam int DEF_MAX_BLOCKS            = 256;
    localparam int DEF_BLOCKS_PER_DESCRIPTOR = 8;

    // A chain never holds more than this many descriptors.
    localparam int CHAIN_MAX = 32;

    // Each descriptor table entry is 16 bytes, so the next pointer is index << 4.
    localparam int ENTRY_SHIFT = 4;

    // Fixed field widths of the request and the descriptor.
    localparam int BLK_COUNT_W = 16;
    localparam int BLK_SIZE_W  = 16;
    localparam int ADDR_W      = 32;
    localparam int INDEX_W     = 5;
    localparam int BYTE_W      = 19;

    // Number of requests the queue between front and back can hold.
    localparam int QUEUE_DEPTH = 2;

    // Back-end sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } ddcb_state_t;

    // Queue status seen by the front end and the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } ddcb_q_status_t;

    // Largest block count that is accepted: the block limit or what fits in a full chain.
    function automatic int chain_limit(input int per, input int max_blocks);
        int chain_blocks;
        chain_blocks = CHAIN_MAX * per;
        return (max_blocks < chain_blocks) ? max_blocks : chain_blocks;
    endfunction

    // Width of the remaining-block counter for a given configuration.
    function automatic int left_width(input int per, input int max_blocks);
        return $clog2(chain_limit(per, max_blocks) + 1);
    endfunction

endpackage

/* design/ddcb_front.sv */
// Front end of the descriptor chain builder: accepts requests and classifies them.
// Depends on ddcb_pkg; feeds ddcb_queue.
module ddcb_front
    import ddcb_pkg::*;
#(
    parameter int MAX_BLOCKS            = DEF_MAX_BLOCKS,
    parameter int BLOCKS_PER_DESCRIPTOR = DEF_BLOCKS_PER_DESCRIPTOR,
    parameter int ENTRY_W               = 1 + BLK_SIZE_W + ADDR_W +
                                          left_width(BLOCKS_PER_DESCRIPTOR, MAX_BLOCKS)
)
(
    input  logic                   start,
    input  logic [BLK_COUNT_W-1:0] block_count,
    input  logic [BLK_SIZE_W-1:0]  block_size,
    input  logic [ADDR_W-1:0]      buffer_base,
    input  ddcb_q_status_t         q_status,
    output logic                   busy,
    output logic                   push,
    output logic [ENTRY_W-1:0]     entry
);

    localparam int LIMIT  = chain_limit(BLOCKS_PER_DESCRIPTOR, MAX_BLOCKS);
    localparam int LEFT_W = left_width(BLOCKS_PER_DESCRIPTOR, MAX_BLOCKS);

    logic              over_limit;
    logic [LEFT_W-1:0] left_count;

    // The block takes a new request whenever the queue has room.
    assign busy = q_status.full;
    assign push = start && !q_status.full;

    // A request over the limit is rejected; otherwise its block count fits the counter.
    assign over_limit = (32'(block_count) > 32'(LIMIT));
    assign left_count = over_limit ? '0 : LEFT_W'(block_count);

    // Queue entry layout: rejected, remaining blocks, block size, buffer base.
    assign entry = {over_limit, left_count, block_size, buffer_base};

endmodule

/* design/ddcb_queue.sv */
// Short request queue between the front end and the back end.
// Depends on ddcb_pkg.
module ddcb_queue
    import ddcb_pkg::*;
#(
    parameter int ENTRY_W = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [ENTRY_W-1:0] push_entry,
    input  logic               pop,
    output logic [ENTRY_W-1:0] head_entry,
    output ddcb_q_status_t     q_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    // Status flags.
    assign q_status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;

    // Pointer and fill-count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; only filled slots are ever read.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry = slot_reg[rd_ptr_reg];

endmodule

/* design/ddcb_back.sv */
// Back end of the descriptor chain builder: walks one request and emits its descriptors.
// Depends on ddcb_pkg; reads requests from ddcb_queue.
module ddcb_back
    import ddcb_pkg::*;
#(
    parameter int PAGE_BYTES            = DEF_PAGE_BYTES,
    parameter int MAX_BLOCKS            = DEF_MAX_BLOCKS,
    parameter int BLOCKS_PER_DESCRIPTOR = DEF_BLOCKS_PER_DESCRIPTOR,
    parameter int ENTRY_W               = 1 + BLK_SIZE_W + ADDR_W +
                                          left_width(BLOCKS_PER_DESCRIPTOR, MAX_BLOCKS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ddcb_q_status_t     q_status,
    input  logic [ENTRY_W-1:0] head_entry,
    input  logic [ADDR_W-1:0]  table_base,
    output logic               pop,
    output logic               result_valid,
    output logic [INDEX_W-1:0] descriptor_index,
    output logic               owned_by_dma,
    output logic               chained,
    output logic               first_segment,
    output logic               last_segment,
    output logic [BYTE_W-1:0]  byte_count,
    output logic [ADDR_W-1:0]  buffer_address,
    output logic [ADDR_W-1:0]  next_address,
    output logic               rejected,
    output logic               end_of_run
);

    localparam int LEFT_W = left_width(BLOCKS_PER_DESCRIPTOR, MAX_BLOCKS);
    localparam int SEG_W  = $clog2(BLOCKS_PER_DESCRIPTOR + 1);
    localparam int PROD_W = BLK_SIZE_W + SEG_W;

    ddcb_state_t state_reg;
    ddcb_state_t state_next;

    // Working registers of the request in progress.
    logic [LEFT_W-1:0]     left_reg;
    logic [BLK_SIZE_W-1:0] bsize_reg;
    logic [ADDR_W-1:0]     buf_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic                  rej_reg;

    // Output registers.
    logic                  valid_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic                  owned_reg;
    logic                  first_reg;
    logic                  last_reg;
    logic [BYTE_W-1:0]     bytes_reg;
    logic [ADDR_W-1:0]     baddr_reg;
    logic [ADDR_W-1:0]     naddr_reg;
    logic                  rejected_reg;
    logic                  eor_reg;

    // Head entry fields.
    logic                  head_rej;
    logic [LEFT_W-1:0]     head_left;
    logic [BLK_SIZE_W-1:0] head_bsize;
    logic [ADDR_W-1:0]     head_base;

    logic                  emit;
    logic                  is_last;
    logic [SEG_W-1:0]      seg;
    logic [PROD_W-1:0]     prod;
    logic [ADDR_W-1:0]     entry_offset;

    assign {head_rej, head_left, head_bsize, head_base} = head_entry;

    // Segment of the current descriptor: the remainder on the final one, else a full group.
    assign is_last = rej_reg || (32'(left_reg) <= 32'(BLOCKS_PER_DESCRIPTOR));
    assign seg     = is_last ? SEG_W'(left_reg) : SEG_W'(BLOCKS_PER_DESCRIPTOR);
    assign prod    = PROD_W'(bsize_reg) * PROD_W'(seg);

    // Offset of the entry after this one in the descriptor table.
    assign entry_offset = (ADDR_W'(idx_reg) + 1'b1) << ENTRY_SHIFT;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (is_last && q_status.empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: emit a descriptor each running cycle, load the next request when free.
    always_comb
    begin
        emit = 1'b0;
        pop  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop = !q_status.empty;
            end
            ST_RUN:
            begin
                emit = 1'b1;
                pop  = is_last && !q_status.empty;
            end
            default:
            begin
                emit = 1'b0;
                pop  = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= emit;
        end
    end

    // Working registers: reload when a request is taken, else advance on each descriptor.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            left_reg  <= head_left;
            bsize_reg <= head_bsize;
            buf_reg   <= head_base;
            idx_reg   <= '0;
            rej_reg   <= head_rej;
        end
        else if (emit)
        begin
            left_reg <= left_reg - LEFT_W'(BLOCKS_PER_DESCRIPTOR);
            buf_reg  <= buf_reg + ADDR_W'(PAGE_BYTES);
            idx_reg  <= idx_reg + 1'b1;
        end
    end

    // Result registers; a rejected request shows zeros besides its two marks.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            index_reg    <= rej_reg ? '0 : idx_reg;
            owned_reg    <= !rej_reg;
            first_reg    <= !rej_reg && (idx_reg == '0);
            last_reg     <= !rej_reg && is_last;
            bytes_reg    <= rej_reg ? '0 : BYTE_W'(prod);
            baddr_reg    <= rej_reg ? '0 : buf_reg;
            naddr_reg    <= rej_reg ? '0 : table_base + entry_offset;
            rejected_reg <= rej_reg;
            eor_reg      <= is_last;
        end
    end

    assign result_valid     = valid_reg;
    assign descriptor_index = index_reg;
    assign owned_by_dma     = owned_reg;
    assign chained          = owned_reg;
    assign first_segment    = first_reg;
    assign last_segment     = last_reg;
    assign byte_count       = bytes_reg;
    assign buffer_address   = baddr_reg;
    assign next_address     = naddr_reg;
    assign rejected         = rejected_reg;
    assign end_of_run       = eor_reg;

endmodule

/* design/dma_descriptor_chain_builder.sv */
// DMA descriptor chain builder, top level.
// Depends on ddcb_pkg, ddcb_front, ddcb_queue and ddcb_back.
//
// Usage: a request (block_count, block_size, buffer_base) is taken at a rising
// clock edge where start is high and busy is low. Each request produces a chain
// of descriptors, one per cycle, each shown for exactly one cycle with
// result_valid high; end_of_run marks the final result of a request. A request
// above the block limit gives a single result with rejected set.
// The descriptor table base register is written with cfg_write_en and
// cfg_write_data; the user must write it only while the block is idle, which
// the block itself does not enforce. It resets to zero. A request passes the
// queue and the back end's working registers before its first descriptor shows.
// Each request gives N descriptors, N = ceil(block_count / group) with a
// minimum of one, at most 32; the back-end sequencer emits one descriptor per
// cycle, and starts a queued chain straight after the previous one.
// A two-entry request queue lets the front take requests while a chain runs;
// busy is high while the queue is full.
// Reset clears the queue and the sequencer. The receiver cannot stall results.
module dma_descriptor_chain_builder
    import ddcb_pkg::*;
#(
    parameter int PAGE_BYTES            = DEF_PAGE_BYTES,
    parameter int MAX_BLOCKS            = DEF_MAX_BLOCKS,
    parameter int BLOCKS_PER_DESCRIPTOR = DEF_BLOCKS_PER_DESCRIPTOR
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [ADDR_W-1:0]      cfg_write_data,
    input  logic                   start,
    output logic                   busy,
    input  logic [BLK_COUNT_W-1:0] block_count,
    input  logic [BLK_SIZE_W-1:0]  block_size,
    input  logic [ADDR_W-1:0]      buffer_base,
    output logic                   result_valid,
    output logic [INDEX_W-1:0]     descriptor_index,
    output logic                   owned_by_dma,
    output logic                   chained,
    output logic                   first_segment,
    output logic                   last_segment,
    output logic [BYTE_W-1:0]      byte_count,
    output logic [ADDR_W-1:0]      buffer_address,
    output logic [ADDR_W-1:0]      next_address,
    output logic                   rejected,
    output logic                   end_of_run
);

    localparam int ENTRY_W = 1 + BLK_SIZE_W + ADDR_W +
                             left_width(BLOCKS_PER_DESCRIPTOR, MAX_BLOCKS);

    logic [ADDR_W-1:0]  table_base_reg;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_entry;
    logic [ENTRY_W-1:0] head_entry;
    ddcb_q_status_t     q_status;

    // Descriptor table base register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_base_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            table_base_reg <= cfg_write_data;
        end
    end

    // Request intake and classification.
    ddcb_front #(
        .MAX_BLOCKS            (MAX_BLOCKS),
        .BLOCKS_PER_DESCRIPTOR (BLOCKS_PER_DESCRIPTOR),
        .ENTRY_W               (ENTRY_W)
    ) u_front (
        .start       (start),
        .block_count (block_count),
        .block_size  (block_size),
        .buffer_base (buffer_base),
        .q_status    (q_status),
        .busy        (busy),
        .push        (push),
        .entry       (push_entry)
    );

    // Request queue between front and back.
    ddcb_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    // Descriptor generation.
    ddcb_back #(
        .PAGE_BYTES            (PAGE_BYTES),
        .MAX_BLOCKS            (MAX_BLOCKS),
        .BLOCKS_PER_DESCRIPTOR (BLOCKS_PER_DESCRIPTOR),
        .ENTRY_W               (ENTRY_W)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_status         (q_status),
        .head_entry       (head_entry),
        .table_base       (table_base_reg),
        .pop              (pop),
        .result_valid     (result_valid),
        .descriptor_index (descriptor_index),
        .owned_by_dma     (owned_by_dma),
        .chained          (chained),
        .first_segment    (first_segment),
        .last_segment     (last_segment),
        .byte_count       (byte_count),
        .buffer_address   (buffer_address),
        .next_address     (next_address),
        .rejected         (rejected),
        .end_of_run       (end_of_run)
    );

endmodule

/* tb/tb_dma_descriptor_chain_builder.sv */
// Self-checking testbench for the DMA descriptor chain builder.
// It predicts each descriptor chain and compares every result strobe against it.
// Depends on ddcb_pkg and dma_descriptor_chain_builder.
module tb_dma_descriptor_chain_builder;
    import ddcb_pkg::*;

    localparam int PAGE_BYTES            = DEF_PAGE_BYTES;
    localparam int MAX_BLOCKS            = DEF_MAX_BLOCKS;
    localparam int BLOCKS_PER_DESCRIPTOR = DEF_BLOCKS_PER_DESCRIPTOR;
    localparam int TIMEOUT               = 400000;

    // One transfer request as presented on the input ports.
    typedef struct packed {
        logic [BLK_COUNT_W-1:0] count;
        logic [BLK_SIZE_W-1:0]  size;
        logic [ADDR_W-1:0]      base;
    } request_t;

    // One descriptor (or rejection) as seen on the result ports.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               owned;
        logic               chained;
        logic               first;
        logic               last;
        logic [BYTE_W-1:0]  bytes;
        logic [ADDR_W-1:0]  buf_addr;
        logic [ADDR_W-1:0]  link_ptr;
        logic               rejected;
        logic               end_run;
    } descriptor_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [ADDR_W-1:0]      cfg_write_data = '0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [BLK_COUNT_W-1:0] block_count = '0;
    logic [BLK_SIZE_W-1:0]  block_size = '0;
    logic [ADDR_W-1:0]      buffer_base = '0;
    logic                   result_valid;
    logic [INDEX_W-1:0]     descriptor_index;
    logic                   owned_by_dma;
    logic                   chained;
    logic                   first_segment;
    logic                   last_segment;
    logic [BYTE_W-1:0]      byte_count;
    logic [ADDR_W-1:0]      buffer_address;
    logic [ADDR_W-1:0]      next_address;
    logic                   rejected;
    logic                   end_of_run;

    request_t      pending_reqs[$];
    descriptor_t   expected_descs[$];
    logic [31:0]   table_base = '0;
    bit            no_idle = 1'b0;
    bit            draining = 1'b0;
    int            error_count = 0;
    int            request_count = 0;
    int            reject_count = 0;
    int            desc_checked = 0;
    int            base_writes = 0;

    dma_descriptor_chain_builder #(
        .PAGE_BYTES            (PAGE_BYTES),
        .MAX_BLOCKS            (MAX_BLOCKS),
        .BLOCKS_PER_DESCRIPTOR (BLOCKS_PER_DESCRIPTOR)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .start            (start),
        .busy             (busy),
        .block_count      (block_count),
        .block_size       (block_size),
        .buffer_base      (buffer_base),
        .result_valid     (result_valid),
        .descriptor_index (descriptor_index),
        .owned_by_dma     (owned_by_dma),
        .chained          (chained),
        .first_segment    (first_segment),
        .last_segment     (last_segment),
        .byte_count       (byte_count),
        .buffer_address   (buffer_address),
        .next_address     (next_address),
        .rejected         (rejected),
        .end_of_run       (end_of_run)
    );

    always #1 clk = ~clk;

    // Work out the descriptor chain for one accepted request and queue it.
    function automatic void build_chain(input request_t req);
        int unsigned ndesc;
        int unsigned left;
        int unsigned seg;
        int unsigned i;
        logic [31:0] prod;
        descriptor_t d;
        request_count++;
        ndesc = (req.count + BLOCKS_PER_DESCRIPTOR - 1) / BLOCKS_PER_DESCRIPTOR;
        if (ndesc == 0)
            ndesc = 1;
        // Over the block limit: a single rejection with end_run set and every other field zero.
        if (req.count > MAX_BLOCKS || ndesc > CHAIN_MAX)
        begin
            d = '0;
            d.rejected = 1'b1;
            d.end_run = 1'b1;
            expected_descs.push_back(d);
            reject_count++;
            return;
        end
        left = req.count;
        for (i = 0; i < ndesc; i++)
        begin
            seg = (i + 1 == ndesc) ? left : BLOCKS_PER_DESCRIPTOR;
            prod = req.size * seg;
            d.index = i[INDEX_W-1:0];
            d.owned = 1'b1;
            d.chained = 1'b1;
            d.first = (i == 0);
            d.last = (i + 1 == ndesc);
            d.bytes = prod[BYTE_W-1:0];
            d.buf_addr = req.base + 32'(i * PAGE_BYTES);
            d.link_ptr = table_base + ((i + 1) << ENTRY_SHIFT);
            d.rejected = 1'b0;
            d.end_run = d.last;
            expected_descs.push_back(d);
            left -= seg;
        end
    endfunction

    // Random request: mostly legal chains, some exact multiples, some over the limit.
    function automatic request_t random_request();
        request_t r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            r.count = 16'($urandom_range(MAX_BLOCKS + 1, 65535));
        else if (pick < 35)
            r.count = 16'($urandom_range(0, CHAIN_MAX) * BLOCKS_PER_DESCRIPTOR);
        else
            r.count = 16'($urandom_range(0, MAX_BLOCKS));
        pick = $urandom_range(99);
        if (pick < 10)
            r.size = '0;
        else if (pick < 20)
            r.size = '1;
        else
            r.size = 16'($urandom);
        // Some buffers sit just below the top of the address space so the chain wraps.
        if ($urandom_range(99) < 15)
            r.base = 32'hFFFF_FFFF - 32'($urandom_range(0, 32'h0002_0000));
        else
            r.base = $urandom;
        return r;
    endfunction

    task automatic queue_request(input int unsigned count, input int unsigned size,
                                 input logic [31:0] base);
        request_t r;
        r.count = count[BLK_COUNT_W-1:0];
        r.size = size[BLK_SIZE_W-1:0];
        r.base = base;
        pending_reqs.push_back(r);
    endtask

    // Block until every queued request has been taken and every result has come.
    task automatic wait_for_drain();
        while (pending_reqs.size() != 0 || expected_descs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the descriptor table base while the block is idle.
    task automatic write_table_base(input logic [31:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        table_base = value;
        base_writes++;
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_reqs.push_back(random_request());
    endtask

    // Driver: presents the oldest pending request and holds it until the transfer.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic go;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            go = start && busy;
            if (start && !busy)
            begin
                build_chain(pending_reqs.pop_front());
                // Now and then hold off until the whole backlog of results is out.
                if ($urandom_range(99) < 5)
                    draining = 1'b1;
            end
            if (draining && expected_descs.size() == 0)
                draining = 1'b0;
            if (!go && pending_reqs.size() != 0 && !draining)
                go = no_idle || ($urandom_range(99) >= 19);
            start <= go;
            if (go)
            begin
                block_count <= pending_reqs[0].count;
                block_size <= pending_reqs[0].size;
                buffer_base <= pending_reqs[0].base;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    // Monitor: every result strobe is matched against the oldest expected descriptor.
    always @(posedge clk)
    begin : monitor
        descriptor_t want;
        if (rst_n && result_valid)
        begin
            if (expected_descs.size() == 0)
            begin
                $error("descriptor %0d arrived with nothing expected", descriptor_index);
                error_count++;
            end
            else
            begin
                want = expected_descs.pop_front();
                desc_checked++;
                check_field("descriptor_index", want.index, descriptor_index);
                check_field("owned_by_dma", want.owned, owned_by_dma);
                check_field("chained", want.chained, chained);
                check_field("first_segment", want.first, first_segment);
                check_field("last_segment", want.last, last_segment);
                check_field("byte_count", want.bytes, byte_count);
                check_field("buffer_address", want.buf_addr, buffer_address);
                check_field("next_address", want.link_ptr, next_address);
                check_field("rejected", want.rejected, rejected);
                check_field("end_of_run", want.end_run, end_of_run);
            end
        end
    end

    // Stimulus: directed corners at the reset table base, then random phases.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Zero blocks, single partial descriptor and the exact-multiple boundary.
        queue_request(0, 512, 32'h1000_0000);
        queue_request(1, 512, 32'h0000_0000);
        queue_request(7, 65535, 32'hFFFF_FFFF);
        queue_request(8, 65535, 32'h8000_0000);
        queue_request(9, 0, 32'h1234_5678);
        queue_request(16, 1, 32'hFFFF_F000);
        queue_request(17, 16'hAAAA, 32'h5555_5555);
        queue_request(255, 16'h5555, 32'hAAAA_AAAA);
        // Full 32-descriptor chain at the block limit, with the buffer wrapping.
        queue_request(MAX_BLOCKS, 65535, 32'hFFFF_FFFF);
        queue_request(MAX_BLOCKS - 8, 4096, 32'hFFFE_0000);
        // Requests over the limit are rejected, followed by two legal requests.
        queue_request(MAX_BLOCKS + 1, 512, 32'h0000_0000);
        queue_request(16'h8000, 1, 32'h0000_0000);
        queue_request(65535, 65535, 32'hFFFF_FFFF);
        queue_request(24, 16'h8001, 32'h7FFF_FFFF);
        queue_request(0, 0, 32'hFFFF_FFFF);
        wait_for_drain();

        // Table base near the top so next pointers wrap.
        write_table_base(32'hFFFF_FFF0);
        queue_random(25);
        wait_for_drain();

        // Random base, and a long stretch where the sender never idles.
        write_table_base($urandom);
        no_idle = 1'b1;
        queue_random(25);
        wait_for_drain();
        no_idle = 1'b0;

        write_table_base(32'hFFFF_FFFF);
        queue_random(25);
        wait_for_drain();

        write_table_base(32'h0000_0000);
        queue_random(25);
        wait_for_drain();
        repeat (8) @(posedge clk);

        $display("Covered %0d requests (%0d rejected) and checked %0d descriptors",
                 request_count, reject_count, desc_checked);
        $display("across %0d table base settings after the reset value.", base_writes);
        if (error_count == 0 && expected_descs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a hung handshake or a missing result.
    initial
    begin
        #(TIMEOUT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
